@@ hw/rtl/sha256_pkg.sv @@
`default_nettype none

package sha256_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned NUM_HASH_WORDS = 8;
    localparam int unsigned WINDOW_DEPTH   = 16;
    localparam int unsigned NUM_ROUNDS     = 64;

    localparam logic [2:0]  BYTES_PER_WORD = 3'd4;
    localparam logic [3:0]  LEN_HI_SLOT    = 4'd14;
    localparam logic [3:0]  LAST_SLOT      = 4'd15;
    localparam logic [5:0]  LAST_ROUND     = 6'd63;
    localparam logic [2:0]  LAST_OUT_INDEX = 3'd7;
    localparam t_word       PAD_MARK_WORD  = 32'h8000_0000;
    localparam logic [63:0] WORD_BITS      = 64'd32;

    localparam t_word INITIAL_HASH [NUM_HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        CS_COLLECT,
        CS_ROUND,
        CS_UPDATE
    } t_core_state;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_PAD,
        TS_OUT
    } t_top_state;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN_LO
    } t_pad_phase;

    typedef struct packed {
        logic  push;
        t_word word;
        logic  reinit;
    } t_core_ctl;

    typedef struct packed {
        logic       busy;
        logic [3:0] words;
    } t_core_stat;

endpackage

`default_nettype wire

@@ hw/rtl/sha256_core.sv @@
`default_nettype none

module sha256_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sha256_pkg::t_core_ctl i_ctl,
    output sha256_pkg::t_core_stat     o_stat,
    output sha256_pkg::t_word          o_hash [sha256_pkg::NUM_HASH_WORDS]
);

    function automatic sha256_pkg::t_word rotr(input sha256_pkg::t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    sha256_pkg::t_core_state r_state;
    sha256_pkg::t_core_state n_state;
    logic [3:0]              r_words;
    logic [3:0]              n_words;
    logic [5:0]              r_round;
    sha256_pkg::t_word       r_hash [sha256_pkg::NUM_HASH_WORDS];
    sha256_pkg::t_word       r_v    [sha256_pkg::NUM_HASH_WORDS];
    sha256_pkg::t_word       r_win  [sha256_pkg::WINDOW_DEPTH];

    sha256_pkg::t_word big_s0;
    sha256_pkg::t_word big_s1;
    sha256_pkg::t_word ch;
    sha256_pkg::t_word maj;
    sha256_pkg::t_word t1;
    sha256_pkg::t_word t2;
    sha256_pkg::t_word new_w;

    always_comb begin
        big_s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        big_s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + big_s1 + ch + sha256_pkg::ROUND_K[r_round] + r_win[0];
        t2     = big_s0 + maj;
        new_w  = (rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10))
               + r_win[9]
               + (rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3))
               + r_win[0];
    end

    always_comb begin
        n_state = r_state;
        n_words = r_words;
        unique case (r_state)
            sha256_pkg::CS_COLLECT: begin
                if (i_ctl.push) begin
                    n_words = r_words + 4'd1;
                    if (r_words == sha256_pkg::LAST_SLOT) begin
                        n_state = sha256_pkg::CS_ROUND;
                    end
                end
            end
            sha256_pkg::CS_ROUND: begin
                if (r_round == sha256_pkg::LAST_ROUND) begin
                    n_state = sha256_pkg::CS_UPDATE;
                end
            end
            sha256_pkg::CS_UPDATE: begin
                n_state = sha256_pkg::CS_COLLECT;
            end
            default: begin
                n_state = sha256_pkg::CS_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::CS_COLLECT;
            r_words <= '0;
            r_round <= '0;
            r_hash  <= sha256_pkg::INITIAL_HASH;
        end else begin
            r_state <= n_state;
            r_words <= n_words;
            if (r_state == sha256_pkg::CS_ROUND) begin
                r_round <= r_round + 6'd1;
            end else begin
                r_round <= '0;
            end
            if (r_state == sha256_pkg::CS_UPDATE) begin
                for (int i = 0; i < sha256_pkg::NUM_HASH_WORDS; i++) begin
                    r_hash[i] <= r_hash[i] + r_v[i];
                end
            end else if (r_state == sha256_pkg::CS_COLLECT && i_ctl.reinit) begin
                r_hash <= sha256_pkg::INITIAL_HASH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sha256_pkg::CS_COLLECT && i_ctl.push) begin
            for (int i = 0; i < sha256_pkg::WINDOW_DEPTH - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[sha256_pkg::WINDOW_DEPTH - 1] <= i_ctl.word;
            if (r_words == sha256_pkg::LAST_SLOT) begin
                r_v <= r_hash;
            end
        end else if (r_state == sha256_pkg::CS_ROUND) begin
            for (int i = 0; i < sha256_pkg::WINDOW_DEPTH - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[sha256_pkg::WINDOW_DEPTH - 1] <= new_w;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_stat.busy  = (r_state != sha256_pkg::CS_COLLECT);
    assign o_stat.words = r_words;
    assign o_hash       = r_hash;

endmodule

`default_nettype wire

@@ hw/rtl/sha256_message_digest_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_data_word, i_byte_count, i_last
// output    out        o_out_valid / i_out_ready o_digest_word, o_word_index, o_last_word
//
// A message word is taken when the round unit is not busy; the word that completes a
// 512-bit block starts 64 rounds and one hash update in the round unit, and no further
// word is taken until they are done. A last word adds the padding words and one or two
// compressions, then eight digest words, one per cycle while the output is taken.
// Reset is synchronous and active low and restores the initial hash.

module sha256_message_digest_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    sha256_pkg::t_top_state r_state;
    sha256_pkg::t_top_state n_state;
    sha256_pkg::t_pad_phase r_phase;
    sha256_pkg::t_pad_phase n_phase;
    logic [2:0]             r_out_idx;
    logic [2:0]             n_out_idx;
    logic [63:0]            r_bit_len;
    logic [63:0]            n_bit_len;

    sha256_pkg::t_core_ctl  core_ctl;
    sha256_pkg::t_core_stat core_stat;
    sha256_pkg::t_word      hash [sha256_pkg::NUM_HASH_WORDS];

    logic [2:0]             n_eff;
    sha256_pkg::t_word      first_word;

    sha256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_stat  (core_stat),
        .o_hash  (hash)
    );

    always_comb begin
        n_eff = (i_byte_count > sha256_pkg::BYTES_PER_WORD) ? sha256_pkg::BYTES_PER_WORD
                                                             : i_byte_count;
        unique case (n_eff)
            3'd0:    first_word = sha256_pkg::PAD_MARK_WORD;
            3'd1:    first_word = {i_data_word[31:24], 24'h80_0000};
            3'd2:    first_word = {i_data_word[31:16], 16'h8000};
            3'd3:    first_word = {i_data_word[31:8], 8'h80};
            default: first_word = i_data_word;
        endcase
    end

    always_comb begin
        n_state         = r_state;
        n_phase         = r_phase;
        n_out_idx       = r_out_idx;
        n_bit_len       = r_bit_len;
        core_ctl.push   = 1'b0;
        core_ctl.word   = '0;
        core_ctl.reinit = 1'b0;
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        unique case (r_state)
            sha256_pkg::TS_IDLE: begin
                o_in_ready = !core_stat.busy;
                if (i_in_valid && !core_stat.busy) begin
                    core_ctl.push = 1'b1;
                    if (!i_last) begin
                        core_ctl.word = i_data_word;
                        n_bit_len     = r_bit_len + sha256_pkg::WORD_BITS;
                    end else begin
                        core_ctl.word = first_word;
                        n_bit_len     = r_bit_len + {58'd0, n_eff, 3'd0};
                        n_state       = sha256_pkg::TS_PAD;
                        n_phase       = (n_eff == sha256_pkg::BYTES_PER_WORD)
                                      ? sha256_pkg::PH_MARK : sha256_pkg::PH_ZERO;
                    end
                end
            end
            sha256_pkg::TS_PAD: begin
                if (!core_stat.busy) begin
                    core_ctl.push = 1'b1;
                    unique case (r_phase)
                        sha256_pkg::PH_MARK: begin
                            core_ctl.word = sha256_pkg::PAD_MARK_WORD;
                            n_phase       = sha256_pkg::PH_ZERO;
                        end
                        sha256_pkg::PH_ZERO: begin
                            if (core_stat.words == sha256_pkg::LEN_HI_SLOT) begin
                                core_ctl.word = r_bit_len[63:32];
                                n_phase       = sha256_pkg::PH_LEN_LO;
                            end
                        end
                        sha256_pkg::PH_LEN_LO: begin
                            core_ctl.word = r_bit_len[31:0];
                            n_state       = sha256_pkg::TS_OUT;
                        end
                        default: begin
                            core_ctl.push = 1'b0;
                            n_phase       = sha256_pkg::PH_ZERO;
                        end
                    endcase
                end
            end
            sha256_pkg::TS_OUT: begin
                o_out_valid = !core_stat.busy;
                if (!core_stat.busy && i_out_ready) begin
                    if (r_out_idx == sha256_pkg::LAST_OUT_INDEX) begin
                        core_ctl.reinit = 1'b1;
                        n_bit_len       = '0;
                        n_out_idx       = '0;
                        n_state         = sha256_pkg::TS_IDLE;
                    end else begin
                        n_out_idx = r_out_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::TS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sha256_pkg::TS_IDLE;
            r_phase   <= sha256_pkg::PH_ZERO;
            r_out_idx <= '0;
            r_bit_len <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_out_idx <= n_out_idx;
            r_bit_len <= n_bit_len;
        end
    end

    assign o_digest_word = hash[r_out_idx];
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == sha256_pkg::LAST_OUT_INDEX);

endmodule

`default_nettype wire

@@ dv/sha256_message_digest_unit_tb.sv @@
`timescale 1ns / 1ps

typedef struct {
    sha256_pkg::t_word digest;
    logic [2:0]        idx;
    logic              fin;
} t_digest_expect;

class sha256_digest_scoreboard;
    sha256_pkg::t_word chain [8];
    sha256_pkg::t_word block_buf [16];
    int unsigned       fill;
    logic [63:0]       msg_bits;
    t_digest_expect    digest_q [$];
    int unsigned       mismatches;
    int unsigned       digests_checked;
    int unsigned       words_noted;
    int unsigned       messages;

    function new();
        mismatches      = 0;
        digests_checked = 0;
        words_noted     = 0;
        messages        = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::INITIAL_HASH[i];
        fill     = 0;
        msg_bits = '0;
    endfunction

    function sha256_pkg::t_word ror(sha256_pkg::t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function sha256_pkg::t_word big0(sha256_pkg::t_word x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function sha256_pkg::t_word big1(sha256_pkg::t_word x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function sha256_pkg::t_word small0(sha256_pkg::t_word x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function sha256_pkg::t_word small1(sha256_pkg::t_word x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function void compress_block();
        sha256_pkg::t_word sched [64];
        sha256_pkg::t_word a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++) sched[t] = block_buf[t];
        for (int t = 16; t < 64; t++) begin
            sched[t] = small1(sched[t-2]) + sched[t-7] + small0(sched[t-15])
                     + sched[t-16];
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + big1(e) + ((e & f) ^ (~e & g)) + sha256_pkg::ROUND_K[t] + sched[t];
            t2 = big0(a) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void absorb(sha256_pkg::t_word w);
        block_buf[fill] = w;
        fill++;
        if (fill == 16) begin
            compress_block();
            fill = 0;
        end
    endfunction

    function void note_word(sha256_pkg::t_word data, logic [2:0] cnt, logic lst);
        int unsigned       nb;
        sha256_pkg::t_word keep;
        t_digest_expect    exp;
        words_noted++;
        nb = (cnt > 3'd4) ? 4 : int'(cnt);
        if (!lst) begin
            msg_bits += 64'd32;
            absorb(data);
            return;
        end
        msg_bits += 64'(8 * nb);
        if (nb == 4) begin
            absorb(data);
            absorb(sha256_pkg::PAD_MARK_WORD);
        end else begin
            keep = ~(32'hFFFF_FFFF >> (8 * nb));
            absorb((data & keep) | (sha256_pkg::PAD_MARK_WORD >> (8 * nb)));
        end
        while (fill != 14) absorb('0);
        absorb(msg_bits[63:32]);
        absorb(msg_bits[31:0]);
        for (int k = 0; k < 8; k++) begin
            exp.digest = chain[k];
            exp.idx    = 3'(k);
            exp.fin    = (k == 7);
            digest_q.insert(digest_q.size(), exp);
        end
        messages++;
        restart();
    endfunction

    function void check_digest(sha256_pkg::t_word got_digest, logic [2:0] got_idx,
                               logic got_fin);
        t_digest_expect exp;
        digests_checked++;
        if (digest_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected digest word %h index %0d last %b with nothing pending.",
                         got_digest, got_idx, got_fin);
            end
            return;
        end
        exp = digest_q.pop_front();
        if (got_digest !== exp.digest || got_idx !== exp.idx || got_fin !== exp.fin) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Digest mismatch: expected %h index %0d last %b,",
                         exp.digest, exp.idx, exp.fin);
                $display("    got %h index %0d last %b", got_digest, got_idx, got_fin);
            end
        end
    endfunction

    function int unsigned pending();
        return digest_q.size();
    endfunction
endclass

module sha256_message_digest_unit_tb;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_WORDS = 170;
    localparam int CALM_WORDS   = 30;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 160;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_data_word;
    logic [2:0]  i_byte_count;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_digest_scoreboard sb = new();

    bit          sender_idles = 1'b1;
    bit          sink_idles   = 1'b1;
    bit          long_hold    = 1'b0;
    int unsigned words_sent   = 0;
    int unsigned quiet_cycles = 0;

    sha256_message_digest_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_word   (i_data_word),
        .i_byte_count  (i_byte_count),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_word(input sha256_pkg::t_word data, input logic [2:0] cnt,
                             input logic lst);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_word  <= data;
        i_byte_count <= cnt;
        i_last       <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(data, cnt, lst);
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_digest(o_digest_word, o_word_index, o_last_word);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : sink
        int span;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold) begin
                i_out_ready <= 1'b0;
                for (span = 0; span < LONG_HOLD; span++) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (sink_idles && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int unsigned directed_words;
        int unsigned len;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_word  <= '0;
        i_byte_count <= '0;
        i_last       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-word messages cover byte counts zero to four on a final word, including
        // the empty message, and the count seven above four.
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_word(32'h1234_5678, 3'd2, 1'b1);
        send_word(32'h6162_63FF, 3'd3, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hDEAD_BEEF, 3'd7, 1'b1);
        // Short counts on words that are not final must be ignored.
        send_word(32'hFFFF_FFFF, 3'd2, 1'b0);
        send_word(32'hA5A5_A5A5, 3'd0, 1'b0);
        send_word(32'h5A5A_5A5A, 3'd5, 1'b1);
        // Fourteen full words push the length field into a second padding block.
        for (int i = 0; i < 13; i++) send_word($urandom, 3'd4, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        directed_words = words_sent;

        long_hold = 1'b1;
        while (words_sent < directed_words + RANDOM_WORDS) begin
            if (words_sent >= directed_words + RANDOM_WORDS - CALM_WORDS) begin
                sender_idles = 1'b0;
                sink_idles   = 1'b0;
            end else begin
                sender_idles = ($urandom_range(0, 2) != 0);
                sink_idles   = ($urandom_range(0, 2) != 0);
            end
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48)
                                               : $urandom_range(1, 16);
            for (int i = 1; i < len; i++) begin
                send_word($urandom,
                          ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4, 1'b0);
            end
            send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages from %0d words (%0d directed),",
                 sb.messages, sb.words_noted, directed_words);
        $display("with random gaps and a %0d-cycle output hold-off; compared %0d digest words.",
                 LONG_HOLD, sb.digests_checked);
        $display("Mismatches: %0d.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
